// File: design/cfah_pkg.sv
// ---------------------------------------------------------------------------
// Case-folded Adler hash package
// Shared widths, the modulus and the per-byte arithmetic helpers.
// ---------------------------------------------------------------------------
package cfah_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned HASH_W = 2 * SUM_W;

  localparam logic [SUM_W:0] HASH_MODULUS = (SUM_W + 1)'(65521);

  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [HASH_W-1:0] hash_t;

  // Fold ASCII capitals to lower case; every other byte passes unchanged
  function automatic byte_t fold_case(input byte_t b);
    byte_t r;
    r = b;
    if (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  // Add two residues, both below the modulus, and reduce once
  function automatic sum_t mod_add(input sum_t a, input sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= HASH_MODULUS) begin
      s = s - HASH_MODULUS;
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

// File: design/cfah_if.sv
// ---------------------------------------------------------------------------
// Case-folded Adler hash channels
// Valid/ready channels for the byte stream in and the hash results out.
// ---------------------------------------------------------------------------
interface cfah_byte_if import cfah_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfah_hash_if import cfah_pkg::*; ();
  logic  valid;
  logic  ready;
  hash_t hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

// File: design/case_folded_adler_hash_unit.sv
// A hash reaches hash_stream after its last byte passes from the input register into the result register.
// Throughput: one byte per cycle, set by the low/high sum update loop, while no final byte waits.
// A final byte waits in the input register only while the result register is full.
// Reset (rst, synchronous) empties both registers and clears both sums to zero.
// ---------------------------------------------------------------------------
// Case-folded Adler hash unit
// Folds each byte to lower case, accumulates low and high sums mod 65521
// and emits {high, low} on the byte marked last, then restarts from zero.
// ---------------------------------------------------------------------------
module case_folded_adler_hash_unit import cfah_pkg::*; (
  input logic         clk,
  input logic         rst,
  cfah_byte_if.sink   char_stream,
  cfah_hash_if.source hash_stream
);

  // Input register
  logic  in_valid;
  byte_t in_byte;
  logic  in_last;

  // Running sums
  sum_t low_sum;
  sum_t high_sum;
  sum_t low_next;
  sum_t high_next;

  // Result register
  logic  out_valid;
  hash_t out_hash;

  logic out_free;
  logic advance;

  // Advance the held byte unless it is final and the result slot is busy
  assign out_free = !out_valid || hash_stream.ready;
  assign advance  = in_valid && (!in_last || out_free);
  assign char_stream.ready = !in_valid || advance;

  // Fold and accumulate
  assign low_next  = mod_add(low_sum, sum_t'(fold_case(in_byte)));
  assign high_next = mod_add(high_sum, low_next);

  // Capture incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_stream.ready) begin
      in_valid <= char_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_stream.ready && char_stream.valid) begin
      in_byte <= char_stream.data_byte;
      in_last <= char_stream.last_byte;
    end
  end

  // Update sums; clear them after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      low_sum  <= '0;
      high_sum <= '0;
    end else if (advance) begin
      if (in_last) begin
        low_sum  <= '0;
        high_sum <= '0;
      end else begin
        low_sum  <= low_next;
        high_sum <= high_next;
      end
    end
  end

  // Load result on the final byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (hash_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_hash <= {high_next, low_next};
    end
  end

  assign hash_stream.valid      = out_valid;
  assign hash_stream.hash_value = out_hash;

  // Sums always stay reduced
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, low_sum} < HASH_MODULUS) && ({1'b0, high_sum} < HASH_MODULUS))
    else $error("running sum not reduced below modulus");

  // A final byte restarts the sums and presents a result
  assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (low_sum == '0) && (high_sum == '0) && out_valid)
    else $error("final byte did not clear sums or load result");

  // A stalled byte stays in the input register
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("stalled byte lost from input register");

endmodule
